[hdl/move_to_front_search_list_core_assert.svh]
// Assertion macros for the move-to-front search list core.
`ifndef MOVE_TO_FRONT_SEARCH_LIST_CORE_ASSERT_SVH
`define MOVE_TO_FRONT_SEARCH_LIST_CORE_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define MTFL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtfl assertion failed");

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define MTFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtfl assertion failed");

`else

`define MTFL_ASSERT_NOW(label, ante, cons)
`define MTFL_ASSERT_NEXT(label, ante, cons)

`endif

`endif

[hdl/mtfl_pkg.sv]
// Shared types and codes for the move-to-front search list core.
`timescale 1ns / 1ps

package mtfl_pkg;

  localparam int unsigned VAL_W = 32;

  localparam logic REQ_APPEND = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic                    req_type;
    logic signed [VAL_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic found;
    logic status;
  } res_t;

  // Broadcast control from the top level to every cell of the list.
  typedef struct packed {
    logic                    cmp_en;
    logic signed [VAL_W-1:0] cmp_key;
    logic                    commit_search;
    logic                    commit_append;
    logic                    any_hit;
    logic signed [VAL_W-1:0] wr_data;
  } cell_ctl_t;

endpackage

[hdl/mtfl_cell.sv]
// One list position: holds an entry, compares it with a key and shifts from its neighbor.
`timescale 1ns / 1ps

module mtfl_cell (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  mtfl_pkg::cell_ctl_t                      ctl,
  input  logic                                     occupied,
  input  logic                                     tail_sel,
  input  logic signed [mtfl_pkg::VAL_W-1:0]        prev_value,
  input  logic                                     seen_in,
  output logic signed [mtfl_pkg::VAL_W-1:0]        value_out,
  output logic                                     seen_out
);

  logic signed [mtfl_pkg::VAL_W-1:0] value_r;
  logic signed [mtfl_pkg::VAL_W-1:0] value_nxt;
  logic                              match_r;
  logic                              match_nxt;
  logic                              shift;

  // A match is captured when the transaction is accepted and held until it commits.
  always_comb begin
    match_nxt = match_r;
    if (ctl.cmp_en) begin
      match_nxt = occupied && (value_r == ctl.cmp_key);
    end
  end

  // Every cell up to and including the first hit takes its neighbor's entry.
  assign shift    = ctl.commit_search && ctl.any_hit && !seen_in;
  assign seen_out = seen_in || match_r;

  always_comb begin
    value_nxt = value_r;
    if (shift) begin
      value_nxt = prev_value;
    end else if (ctl.commit_append && tail_sel) begin
      value_nxt = ctl.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign value_out = value_r;

endmodule

[hdl/move_to_front_search_list_core.sv]
// Top level of the move-to-front search list core: control, count and cell chain.
`timescale 1ns / 1ps
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one request per
// transaction: append item_value at the tail, or search for it and move the
// first matching entry to the head. The output channel (out_valid, out_stall,
// out_data) returns exactly one result per request: found and status.
// The key is compared against every cell as the transaction is accepted; when
// the pending request commits, the first-hit flag ripples down the cell
// chain, the list shifts or appends, and the result is loaded into the output
// register. Each transaction passes a compare step and a commit step through
// the chain, and a new request is held off until the pending one commits.
// A new request is accepted while a finished result waits in the output
// register. If the receiver stalls, the next request is held pending and the
// list is not touched until its result can be loaded.
// Reset empties the list (count zero); entry contents are not cleared.

`include "move_to_front_search_list_core_assert.svh"

module move_to_front_search_list_core #(
  parameter int unsigned DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  mtfl_pkg::req_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output mtfl_pkg::res_t    out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                               pend_r;
  logic                               pend_nxt;
  logic                               type_r;
  logic signed [mtfl_pkg::VAL_W-1:0]  key_r;
  logic [CW-1:0]                      count_r;
  logic [CW-1:0]                      count_nxt;
  logic                               out_valid_r;
  logic                               out_valid_nxt;
  mtfl_pkg::res_t                     out_data_r;
  mtfl_pkg::res_t                     res;

  logic                               in_accept;
  logic                               out_free;
  logic                               commit;
  logic                               full;
  logic                               any_hit;
  mtfl_pkg::cell_ctl_t                ctl;

  logic signed [mtfl_pkg::VAL_W-1:0]  val_chain [DEPTH];
  logic [DEPTH:0]                     seen_chain;
  logic [DEPTH-1:0]                   occ;
  logic [DEPTH-1:0]                   tail_sel;
  logic [DEPTH-1:0]                   first_hit;

  assign in_stall  = pend_r;
  assign in_accept = in_valid && !pend_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = pend_r && out_free;
  assign full      = (count_r == CW'(DEPTH));
  assign any_hit   = seen_chain[DEPTH];

  always_comb begin
    ctl.cmp_en        = in_accept;
    ctl.cmp_key       = in_data.item_value;
    ctl.commit_search = commit && (type_r == mtfl_pkg::REQ_SEARCH);
    ctl.commit_append = commit && (type_r == mtfl_pkg::REQ_APPEND) && !full;
    ctl.any_hit       = any_hit;
    ctl.wr_data       = key_r;
  end

  assign seen_chain[0] = 1'b0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [mtfl_pkg::VAL_W-1:0] prev_value;

      assign occ[gi]      = (CW'(gi) < count_r);
      assign tail_sel[gi] = (count_r == CW'(gi));

      // The head cell shifts in the key itself, which equals the entry that moved.
      if (gi == 0) begin : g_head
        assign prev_value = key_r;
      end else begin : g_body
        assign prev_value = val_chain[gi-1];
      end

      mtfl_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .occupied   (occ[gi]),
        .tail_sel   (tail_sel[gi]),
        .prev_value (prev_value),
        .seen_in    (seen_chain[gi]),
        .value_out  (val_chain[gi]),
        .seen_out   (seen_chain[gi+1])
      );

      assign first_hit[gi] = seen_chain[gi+1] && !seen_chain[gi];
    end
  endgenerate

  always_comb begin
    res.found  = (type_r == mtfl_pkg::REQ_SEARCH) && any_hit;
    res.status = (type_r == mtfl_pkg::REQ_APPEND) && full;
  end

  always_comb begin
    pend_nxt = pend_r;
    if (in_accept) begin
      pend_nxt = 1'b1;
    end else if (commit) begin
      pend_nxt = 1'b0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.commit_append) begin
      count_nxt = count_r + CW'(1);
    end
  end

  assign out_valid_nxt = commit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      type_r <= in_data.req_type;
      key_r  <= in_data.item_value;
    end
    if (commit) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MTFL_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(DEPTH))
  `MTFL_ASSERT_NOW(a_single_first_hit, pend_r, $onehot0(first_hit))
  `MTFL_ASSERT_NEXT(a_search_keeps_count, ctl.commit_search, count_r == $past(count_r))
  `MTFL_ASSERT_NEXT(a_commit_gives_result, commit, out_valid_r && !pend_r)

endmodule
